/* rtl/core/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants for the postfix expression evaluator: stack geometry,
// token and operation codes, status codes and fixed-point widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int VAL_W  = 64;   // Q31.32
  localparam int FRAC_W = 32;
  localparam int TGT_W  = 11;

  // token kinds
  localparam logic KIND_DIGIT = 1'b0;
  localparam logic KIND_OP    = 1'b1;

  // operations
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam logic [TGT_W-1:0] TARGET_RESET = 11'sd10;

  // divider: numerator magnitude shifted up by the fraction width
  localparam int DIV_STEPS = VAL_W + FRAC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

endpackage : rpn_pkg

`default_nettype wire

/* rtl/core/rpn_ram.sv */
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : rpn_ram

`default_nettype wire

/* rtl/core/rpn_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// rpn_expression_evaluator
// Postfix expression evaluator over a Q31.32 operand stack held in RAM.
// ----------------------------------------------------------------------------
// One token per input word. Digits push, operators pop two and push the
// saturated result; the first error sticks until the word marked last, which
// produces one result word (value, status, target hit) and clears the stack.
// Per token: a digit is written straight to the stack; add and subtract do two
// stack reads through the registered RAM read port, then write-back; multiply
// sums four 32x32 partial products from one multiplier; divide is a restoring
// divider, one quotient bit per cycle over 96 bits. A last token then reads
// the bottom of the stack, and waits while an earlier result word is still
// held on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_expression_evaluator
  import rpn_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration: target value
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic signed [TGT_W-1:0] cfg_data_i,
  // token input
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    kind_i,
  input  wire logic        [3:0]       digit_i,
  input  wire logic        [1:0]       operation_i,
  input  wire logic                    last_i,
  // result output
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed      [VAL_W-1:0] value_o,
  output logic             [1:0]       status_o,
  output logic                         hits_target_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD_R = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_WB   = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_MAG = {1'b1, {(VAL_W-1){1'b0}}};

  function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] x);
    mag_of = x[VAL_W-1] ? (~x + 1'b1) : x;
  endfunction

  // sign plus wide magnitude to saturated two's complement
  function automatic logic [VAL_W-1:0] clamp_mag(input logic neg, input logic hi_nz,
                                                 input logic [VAL_W-1:0] lo);
    if (neg) begin
      clamp_mag = (hi_nz || lo > NEG_MAG) ? NEG_MAG : (~lo + 1'b1);
    end else begin
      clamp_mag = (hi_nz || lo > POS_MAX) ? POS_MAX : lo;
    end
  endfunction

  logic [3:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [1:0]             err_q, err_d;
  logic [1:0]             op_q, op_d;
  logic                   last_q, last_d;
  logic                   neg_q, neg_d;
  logic [VAL_W-1:0]       opl_q, opl_d;
  logic [VAL_W-1:0]       opr_q, opr_d;
  logic [VAL_W-1:0]       prod_q, prod_d;
  logic [2*VAL_W-1:0]     acc_q, acc_d;
  logic [DIV_STEPS-1:0]   quo_q, quo_d;
  logic [VAL_W-1:0]       rem_q, rem_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [VAL_W-1:0]       res_q, res_d;
  logic [TGT_W-1:0]       target_q;
  logic                   out_valid_q, out_valid_d;
  logic [VAL_W-1:0]       out_value_q, out_value_d;
  logic [1:0]             out_status_q, out_status_d;
  logic                   out_hit_q, out_hit_d;

  logic                   mem_we, mem_re;
  logic [PTR_W-1:0]       mem_waddr, mem_raddr;
  logic [VAL_W-1:0]       mem_wdata, mem_rdata;

  logic [CNT_W-1:0]       cnt_m1, cnt_m2;
  logic                   in_acc;
  logic [VAL_W-1:0]       sum, diff;
  logic [VAL_W-1:0]       add_res, sub_res;
  logic [FRAC_W-1:0]      a_half, b_half;
  logic [1:0]             pstep;
  logic [2*VAL_W-1:0]     prod_sh;
  logic [VAL_W-1:0]       rem_sh;
  logic                   rem_ge;
  logic [VAL_W-1:0]       tgt_fix;
  logic                   out_free;

  rpn_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign cnt_m2 = cnt_q - CNT_W'(2);

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // add/sub: right operand in opr_q, left operand straight from the RAM
  assign sum  = mem_rdata + opr_q;
  assign diff = mem_rdata - opr_q;
  assign add_res = (mem_rdata[VAL_W-1] == opr_q[VAL_W-1] && sum[VAL_W-1] != mem_rdata[VAL_W-1])
                   ? (mem_rdata[VAL_W-1] ? NEG_MAG : POS_MAX) : sum;
  assign sub_res = (mem_rdata[VAL_W-1] != opr_q[VAL_W-1] && diff[VAL_W-1] != mem_rdata[VAL_W-1])
                   ? (mem_rdata[VAL_W-1] ? NEG_MAG : POS_MAX) : diff;

  // partial product order: a0b0, a0b1, a1b0, a1b1
  assign a_half = step_q[1] ? opl_q[VAL_W-1:FRAC_W] : opl_q[FRAC_W-1:0];
  assign b_half = step_q[0] ? opr_q[VAL_W-1:FRAC_W] : opr_q[FRAC_W-1:0];
  assign pstep  = step_q[1:0] - 2'd1;

  always_comb begin
    case (pstep)
      2'd0:    prod_sh = {{VAL_W{1'b0}}, prod_q};
      2'd3:    prod_sh = {prod_q, {VAL_W{1'b0}}};
      default: prod_sh = {{FRAC_W{1'b0}}, prod_q, {FRAC_W{1'b0}}};
    endcase
  end

  // restoring divide step; rem stays below the divisor, so the shift fits
  assign rem_sh = {rem_q[VAL_W-2:0], quo_q[DIV_STEPS-1]};
  assign rem_ge = (rem_sh >= opr_q);

  assign tgt_fix = {{(VAL_W-FRAC_W-TGT_W){target_q[TGT_W-1]}}, target_q, {FRAC_W{1'b0}}};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    op_d         = op_q;
    last_d       = last_q;
    neg_d        = neg_q;
    opl_d        = opl_q;
    opr_d        = opr_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    step_d       = step_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_hit_d    = out_hit_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q[PTR_W-1:0];
    mem_wdata    = {{(VAL_W-FRAC_W-4){1'b0}}, digit_i, {FRAC_W{1'b0}}};
    mem_re       = 1'b0;
    mem_raddr    = cnt_m1[PTR_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d   = operation_i;
          last_d = last_i;
          state_d = last_i ? S_FIN : S_IDLE;
          if (err_q == ST_OK) begin
            if (kind_i == KIND_DIGIT) begin
              if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
                err_d = ST_OVERFLOW;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end else if (cnt_q < CNT_W'(2)) begin
              err_d = ST_MALFORMED;
            end else begin
              mem_re  = 1'b1;
              state_d = S_RD_R;
            end
          end
        end
      end
      S_RD_R: begin
        opr_d     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = cnt_m2[PTR_W-1:0];
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        neg_d  = mem_rdata[VAL_W-1] ^ opr_q[VAL_W-1];
        opl_d  = mag_of(mem_rdata);
        opr_d  = mag_of(opr_q);
        step_d = '0;
        case (op_q)
          OP_ADD, OP_SUB: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m2[PTR_W-1:0];
            mem_wdata = (op_q == OP_ADD) ? add_res : sub_res;
            cnt_d     = cnt_m1;
            state_d   = last_q ? S_FIN : S_IDLE;
          end
          OP_MUL: begin
            acc_d   = '0;
            state_d = S_MUL;
          end
          default: begin
            if (opr_q == '0) begin
              err_d   = ST_DIV_ZERO;
              state_d = last_q ? S_FIN : S_IDLE;
            end else begin
              quo_d   = {mag_of(mem_rdata), {FRAC_W{1'b0}}};
              rem_d   = '0;
              state_d = S_DIV;
            end
          end
        endcase
      end
      S_MUL: begin
        step_d = step_q + STEP_W'(1);
        if (step_q < STEP_W'(4)) begin
          prod_d = a_half * b_half;
        end
        if (step_q != '0 && step_q < STEP_W'(5)) begin
          acc_d = acc_q + prod_sh;
        end
        if (step_q == STEP_W'(5)) begin
          // product shifted down by the fraction width
          res_d   = clamp_mag(neg_q, |acc_q[2*VAL_W-1:VAL_W+FRAC_W],
                              acc_q[VAL_W+FRAC_W-1:FRAC_W]);
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS)) begin
          res_d   = clamp_mag(neg_q, |quo_q[DIV_STEPS-1:VAL_W], quo_q[VAL_W-1:0]);
          state_d = S_WB;
        end else begin
          rem_d  = rem_ge ? (rem_sh - opr_q) : rem_sh;
          quo_d  = {quo_q[DIV_STEPS-2:0], rem_ge};
          step_d = step_q + STEP_W'(1);
        end
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_m2[PTR_W-1:0];
        mem_wdata = res_q;
        cnt_d     = cnt_m1;
        state_d   = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (err_q == ST_OK && cnt_q != CNT_W'(1)) begin
          err_d = ST_MALFORMED;
        end
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = err_q;
          out_value_d  = (err_q == ST_OK) ? mem_rdata : '0;
          out_hit_d    = (err_q == ST_OK) && (mem_rdata == tgt_fix);
          cnt_d        = '0;
          err_d        = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      step_q      <= '0;
      target_q    <= TARGET_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    last_q       <= last_d;
    neg_q        <= neg_d;
    opl_q        <= opl_d;
    opr_q        <= opr_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    res_q        <= res_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_hit_q    <= out_hit_d;
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign status_o      = out_status_q;
  assign hits_target_o = out_hit_q;

endmodule : rpn_expression_evaluator

`default_nettype wire

/* sim/rpn_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_result_checker
// Watches the token, target and result channels of the postfix evaluator,
// keeps its own Q31.32 operand stack and compares each result word.
// ----------------------------------------------------------------------------
module rpn_result_checker
  import rpn_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic signed [TGT_W-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    kind_i,
  input  logic        [3:0]       digit_i,
  input  logic        [1:0]       operation_i,
  input  logic                    last_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic        [1:0]       status_i,
  input  logic                    hits_target_i,
  output int                      mismatch_count_o,
  output int                      awaited_o,
  output int                      results_o,
  output int                      hits_o,
  output int                      errors_o
);

  localparam logic [VAL_W-1:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
    logic             hit;
  } report_t;

  logic [VAL_W-1:0]        operand_stack [STACK_DEPTH];
  int                      depth;
  logic [1:0]              sticky_status;
  logic signed [TGT_W-1:0] target;
  report_t                 report_q [$];
  report_t                 seen;
  report_t                 want;

  function automatic logic [VAL_W-1:0] magnitude(logic [VAL_W-1:0] x);
    return x[VAL_W-1] ? -x : x;
  endfunction

  function automatic logic [VAL_W-1:0] clamp_q32(logic neg, logic [127:0] mag);
    if (neg) begin
      return (mag > {64'd0, Q_MIN}) ? Q_MIN : -mag[VAL_W-1:0];
    end
    return (mag > {64'd0, Q_MAX}) ? Q_MAX : mag[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] add_q32(logic [VAL_W-1:0] l, logic [VAL_W-1:0] r);
    logic [VAL_W:0] s;
    s = {l[VAL_W-1], l} + {r[VAL_W-1], r};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? Q_MIN : Q_MAX;
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] sub_q32(logic [VAL_W-1:0] l, logic [VAL_W-1:0] r);
    logic [VAL_W:0] s;
    s = {l[VAL_W-1], l} - {r[VAL_W-1], r};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? Q_MIN : Q_MAX;
    return s[VAL_W-1:0];
  endfunction

  // full 128-bit product of magnitudes, fraction truncated
  function automatic logic [VAL_W-1:0] mul_q32(logic [VAL_W-1:0] l, logic [VAL_W-1:0] r);
    logic [127:0] p;
    p = {64'd0, magnitude(l)} * {64'd0, magnitude(r)};
    return clamp_q32(l[VAL_W-1] ^ r[VAL_W-1], p >> FRAC_W);
  endfunction

  function automatic logic [VAL_W-1:0] div_q32(logic [VAL_W-1:0] l, logic [VAL_W-1:0] r);
    logic [127:0] n;
    logic [127:0] q;
    n = {64'd0, magnitude(l)} << FRAC_W;
    q = n / {64'd0, magnitude(r)};
    return clamp_q32(l[VAL_W-1] ^ r[VAL_W-1], q);
  endfunction

  task automatic apply_token(logic kind, logic [3:0] digit, logic [1:0] op, logic last);
    logic [VAL_W-1:0] lhs;
    logic [VAL_W-1:0] rhs;
    logic [VAL_W-1:0] res;
    report_t          rep;
    res = '0;
    if (sticky_status == ST_OK) begin
      if (kind == KIND_DIGIT) begin
        if (depth >= STACK_DEPTH) begin
          sticky_status = ST_OVERFLOW;
        end else begin
          operand_stack[depth] = {28'd0, digit, 32'd0};
          depth++;
        end
      end else if (depth < 2) begin
        sticky_status = ST_MALFORMED;
      end else begin
        rhs = operand_stack[depth-1];
        lhs = operand_stack[depth-2];
        case (op)
          OP_ADD: res = add_q32(lhs, rhs);
          OP_SUB: res = sub_q32(lhs, rhs);
          OP_MUL: res = mul_q32(lhs, rhs);
          OP_DIV: begin
            if (rhs == '0) sticky_status = ST_DIV_ZERO;
            else res = div_q32(lhs, rhs);
          end
        endcase
        if (sticky_status == ST_OK) begin
          depth--;
          operand_stack[depth-1] = res;
        end
      end
    end
    if (last) begin
      if (sticky_status == ST_OK && depth != 1) sticky_status = ST_MALFORMED;
      rep.status = sticky_status;
      rep.value  = (sticky_status == ST_OK) ? operand_stack[0] : '0;
      rep.hit    = (sticky_status == ST_OK) &&
                   (rep.value == {{(VAL_W-TGT_W-FRAC_W){target[TGT_W-1]}}, target, 32'd0});
      report_q.push_back(rep);
      depth         = 0;
      sticky_status = ST_OK;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth            = 0;
      sticky_status    = ST_OK;
      target           = TARGET_RESET;
      report_q.delete();
      mismatch_count_o = 0;
      results_o        = 0;
      hits_o           = 0;
      errors_o         = 0;
      awaited_o       <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = '{value_i, status_i, hits_target_i};
        results_o++;
        if (report_q.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: result word with none awaited: value %h status %0d hit %0b",
                     $realtime, seen.value, seen.status, seen.hit);
          mismatch_count_o++;
        end else begin
          want = report_q.pop_front();
          if (want.hit) hits_o++;
          if (want.status != ST_OK) errors_o++;
          if (seen != want) begin
            if (mismatch_count_o < 10)
              $display("%0t: result %0d exp value %h status %0d hit %0b, got %h %0d %0b",
                       $realtime, results_o, want.value, want.status, want.hit,
                       seen.value, seen.status, seen.hit);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) target = cfg_data_i;
      if (in_valid_i && in_ready_i) apply_token(kind_i, digit_i, operation_i, last_i);
      awaited_o <= report_q.size();
    end
  end

endmodule : rpn_result_checker

/* sim/rpn_expression_evaluator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_expression_evaluator_test
// Token stream and target writes for the postfix evaluator.
// ----------------------------------------------------------------------------
// Directed expressions first (each operation, every error path), then phases
// of random well-formed, chained (saturating) and garbage expressions under
// several targets, with random gaps and output stalls and one long stall.
// ----------------------------------------------------------------------------
module rpn_expression_evaluator_test;
  import rpn_pkg::*;

  localparam int  DRAIN_CYCLES = 128;
  localparam int  HOLD_CYCLES  = 500;
  localparam int  PHASE_TOKENS = 270;
  localparam int  CALM_AFTER   = 1400;
  localparam real TIMEOUT_NS   = 2_400_000.0;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic signed [TGT_W-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    kind_i;
  logic        [3:0]       digit_i;
  logic        [1:0]       operation_i;
  logic                    last_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VAL_W-1:0] value_o;
  logic        [1:0]       status_o;
  logic                    hits_target_o;

  int mismatch_count;
  int awaited;
  int results;
  int hits;
  int errors;
  int tokens_sent;
  bit src_gaps;
  bit sink_stalls;
  bit hold_off_req;

  rpn_expression_evaluator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .digit_i       (digit_i),
    .operation_i   (operation_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .status_o      (status_o),
    .hits_target_o (hits_target_o)
  );

  rpn_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (kind_i),
    .digit_i          (digit_i),
    .operation_i      (operation_i),
    .last_i           (last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_i          (value_o),
    .status_i         (status_o),
    .hits_target_i    (hits_target_o),
    .mismatch_count_o (mismatch_count),
    .awaited_o        (awaited),
    .results_o        (results),
    .hits_o           (hits),
    .errors_o         (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d result words outstanding", awaited);
    $display("FAIL rpn_expression_evaluator");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [3:0] pick_digit();
    if ($urandom_range(0, 3) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  function automatic string op_symbol(logic [1:0] op);
    case (op)
      OP_ADD:  return "+";
      OP_SUB:  return "-";
      OP_MUL:  return "*";
      default: return "/";
    endcase
  endfunction

  function automatic string digit_symbol(logic [3:0] d);
    return $sformatf("%h", d);
  endfunction

  // builds |t| as ((h*10)+tens)*10+units, negated by 0 - x
  function automatic string target_expr(int t);
    int    mag;
    string s;
    mag = (t < 0) ? -t : t;
    s = $sformatf("%ha*%h+a*%h+", 4'(mag / 100), 4'((mag / 10) % 10), 4'(mag % 10));
    return (t < 0) ? {"0", s, "-"} : s;
  endfunction

  function automatic string random_expr();
    int    mode;
    int    pushes;
    int    depth;
    int    n;
    string s;
    mode = $urandom_range(0, 99);
    s    = "";
    if (mode < 15) begin
      // garbage: random kinds and length
      n = $urandom_range(1, 14);
      repeat (n) begin
        if ($urandom_range(0, 99) < 65) s = {s, digit_symbol(pick_digit())};
        else s = {s, op_symbol(2'($urandom_range(0, 3)))};
      end
    end else if (mode < 30) begin
      // long chains reach saturation and tiny quotients
      s = digit_symbol(pick_digit());
      n = $urandom_range(4, 24);
      repeat (n) begin
        s = {s, digit_symbol(pick_digit())};
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: s = {s, op_symbol(OP_MUL)};
          5, 6, 7:       s = {s, op_symbol(OP_DIV)};
          8:             s = {s, op_symbol(OP_SUB)};
          default:       s = {s, op_symbol(OP_ADD)};
        endcase
      end
    end else begin
      pushes = $urandom_range(1, $urandom_range(2, STACK_DEPTH));
      depth  = 0;
      while (pushes > 0 || depth > 1) begin
        if (pushes > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
          s = {s, digit_symbol(pick_digit())};
          depth++;
          pushes--;
        end else begin
          s = {s, op_symbol(2'($urandom_range(0, 3)))};
          depth--;
        end
      end
    end
    return s;
  endfunction

  task automatic put_token(logic kind, logic [3:0] digit, logic [1:0] op, logic last);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    digit_i     <= digit;
    operation_i <= op;
    last_i      <= last;
    do @(posedge clk_i); while (!in_ready_o);
    tokens_sent++;
  endtask

  // one expression, hex digits and + - * /; the unused field is random
  task automatic run_postfix(string expr);
    byte        c;
    logic       fin;
    logic [1:0] op;
    for (int i = 0; i < expr.len(); i++) begin
      c   = expr.getc(i);
      fin = (i == expr.len() - 1);
      if (c == "+" || c == "-" || c == "*" || c == "/") begin
        case (c)
          "+":     op = OP_ADD;
          "-":     op = OP_SUB;
          "*":     op = OP_MUL;
          default: op = OP_DIV;
        endcase
        put_token(KIND_OP, 4'($urandom_range(0, 15)), op, fin);
      end else begin
        put_token(KIND_DIGIT, (c >= "a") ? 4'(c - "a" + 10) : 4'(c - "0"),
                  2'($urandom_range(0, 3)), fin);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_target(int t);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= TGT_W'(t);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int  phase_target [6];
    bit  late;

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    kind_i      <= KIND_DIGIT;
    digit_i     <= '0;
    operation_i <= OP_ADD;
    last_i      <= 1'b0;
    tokens_sent  = 0;
    src_gaps     = 1'b1;
    sink_stalls  = 1'b1;
    hold_off_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, target still at its reset value
    run_postfix("91+");
    run_postfix("f");
    run_postfix("27-6*");
    run_postfix("13/");
    run_postfix("50/3");        // zero divisor, later token ignored
    run_postfix("4+");          // underflow
    run_postfix("12");          // two left at the end
    run_postfix("999999999");   // ninth push overflows

    phase_target = '{-1000, 1000, 0, 7, 0, 0};
    phase_target[4] = int'($urandom_range(0, 2000)) - 1000;
    phase_target[5] = int'($urandom_range(0, 80)) - 40;

    foreach (phase_target[p]) begin
      write_target(phase_target[p]);
      if (p == 1) hold_off_req = 1'b1;
      run_postfix(target_expr(phase_target[p]));
      while (tokens_sent < 28 + (p + 1) * PHASE_TOKENS) begin
        late        = tokens_sent > CALM_AFTER;
        src_gaps    = !late && $urandom_range(0, 3) != 0;
        sink_stalls = !late && $urandom_range(0, 3) != 0;
        run_postfix(random_expr());
      end
    end

    wait_drained();
    $display("%0d tokens over %0d targets: %0d result words, %0d on target, %0d in error",
             tokens_sent, $size(phase_target) + 1, results, hits, errors);
    if (awaited != 0) $display("%0d result words never arrived", awaited);
    if (mismatch_count == 0 && awaited == 0) begin
      $display("PASS rpn_expression_evaluator");
    end else begin
      $display("FAIL rpn_expression_evaluator");
    end
    $finish;
  end

endmodule : rpn_expression_evaluator_test
